// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  LEAD2_MASK  = 8'b0001_1111;
  localparam logic [7:0]  CONT_MASK   = 8'b0011_1111;
  localparam logic [7:0]  LEAD3_MASK  = 8'b0000_1111;
  localparam logic [7:0]  LEAD4_MASK  = 8'b0000_0111;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [9:0]  SURR_MASK   = 10'b11_1111_1111;
  localparam logic [15:0] HI_SURR     = 16'b1101_1000_0000_0000;
  localparam logic [15:0] LO_SURR     = 16'b1101_1100_0000_0000;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_LEAD = 2'd1,
    ERR_TRUNC    = 2'd2,
    ERR_LOW_4B   = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  error_code;
    logic        last_of_run;
    logic        string_done;
  } out_t;

  // One decoded byte's worth of output work. pair: value holds code - 0x10000.
  typedef struct packed {
    logic        pair;
    logic [19:0] value;
    err_e        err;
    logic        done;
  } job_t;

  // Queue occupancy seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/u8u16_front.sv =====
// Front part: accepts UTF-8 bytes, tracks sequence state, emits decoded jobs.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  u8u16_pkg::in_t    in_i,
  input  u8u16_pkg::qstat_t qstat_i,
  output logic              push_o,
  output u8u16_pkg::job_t   job_o
);
  import u8u16_pkg::*;

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;
  logic        disc_q, disc_d;

  logic        accept;
  logic [7:0]  b;
  logic        eos;
  logic [20:0] acc_shift;
  logic [20:0] acc_off;
  logic [1:0]  pend_dec;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign b          = in_i.in_byte;
  assign eos        = in_i.end_of_string;
  assign acc_shift  = {acc_q[14:0], b[5:0] & CONT_MASK[5:0]};
  assign acc_off    = acc_shift - SUPP_BASE;
  assign pend_dec   = pend_q - 2'd1;

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    acc_d  = acc_q;
    disc_d = disc_q;
    push_o = 1'b0;
    job_o  = '{pair: 1'b0, value: '0, err: ERR_NONE, done: eos};

    if (accept) begin
      if (disc_q) begin
        if (eos) begin
          disc_d = 1'b0;
          pend_d = '0;
          len_d  = 3'd1;
          acc_d  = '0;
        end
      end else if (pend_q == 2'd0) begin
        // lead position
        pend_d = '0;
        len_d  = 3'd1;
        acc_d  = '0;
        if (&b[7:3]) begin
          push_o    = 1'b1;
          job_o.err = ERR_BAD_LEAD;
          disc_d    = ~eos;
        end else if (~&b[7:6]) begin
          // ASCII or stray continuation: byte zero-extended
          push_o      = 1'b1;
          job_o.value = {12'd0, b};
        end else if (eos) begin
          push_o    = 1'b1;
          job_o.err = ERR_TRUNC;
        end else if (b[5] == 1'b0) begin
          len_d  = 3'd2;
          pend_d = 2'd1;
          acc_d  = {13'd0, b & LEAD2_MASK};
        end else if (b[4] == 1'b0) begin
          len_d  = 3'd3;
          pend_d = 2'd2;
          acc_d  = {13'd0, b & LEAD3_MASK};
        end else begin
          len_d  = 3'd4;
          pend_d = 2'd3;
          acc_d  = {13'd0, b & LEAD4_MASK};
        end
      end else if (pend_dec != 2'd0) begin
        if (eos) begin
          push_o    = 1'b1;
          job_o.err = ERR_TRUNC;
          pend_d    = '0;
          len_d     = 3'd1;
          acc_d     = '0;
        end else begin
          pend_d = pend_dec;
          acc_d  = acc_shift;
        end
      end else begin
        // sequence complete
        push_o = 1'b1;
        pend_d = '0;
        len_d  = 3'd1;
        acc_d  = '0;
        if (len_q == 3'd4) begin
          if (acc_shift < SUPP_BASE) begin
            job_o.err = ERR_LOW_4B;
            disc_d    = ~eos;
          end else begin
            job_o.pair  = 1'b1;
            job_o.value = acc_off[19:0];
          end
        end else begin
          job_o.value = {4'd0, acc_shift[15:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= 3'd1;
      acc_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_queue.sv =====
// Small job queue between the front and back parts.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_queue #(
  parameter int unsigned Depth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8u16_pkg::job_t   job_i,
  input  logic              pop_i,
  output u8u16_pkg::job_t   job_o,
  output u8u16_pkg::qstat_t qstat_o
);
  import u8u16_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign job_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_back.sv =====
// Back part: expands queued jobs into UTF-16 results behind an output register.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8u16_pkg::job_t   job_i,
  input  u8u16_pkg::qstat_t qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output u8u16_pkg::out_t   out_o
);
  import u8u16_pkg::*;

  logic        vld_q, vld_d;
  out_t        out_q, out_d;
  logic        lo_pend_q, lo_pend_d;
  logic [15:0] lo_unit_q, lo_unit_d;
  logic        lo_done_q, lo_done_d;
  logic        adv;

  assign adv         = ~vld_q | ~out_stall_i;
  assign pop_o       = adv & ~lo_pend_q & ~qstat_i.empty;
  assign out_valid_o = vld_q;
  assign out_o       = out_q;

  always_comb begin
    vld_d     = vld_q;
    out_d     = out_q;
    lo_pend_d = lo_pend_q;
    lo_unit_d = lo_unit_q;
    lo_done_d = lo_done_q;
    if (adv) begin
      if (lo_pend_q) begin
        vld_d     = 1'b1;
        out_d     = '{unit: lo_unit_q, error_code: ERR_NONE,
                      last_of_run: 1'b1, string_done: lo_done_q};
        lo_pend_d = 1'b0;
      end else if (!qstat_i.empty) begin
        vld_d = 1'b1;
        if (job_i.pair) begin
          out_d     = '{unit: HI_SURR | {6'd0, job_i.value[19:10] & SURR_MASK},
                        error_code: ERR_NONE, last_of_run: 1'b0,
                        string_done: job_i.done};
          lo_pend_d = 1'b1;
          lo_unit_d = LO_SURR | {6'd0, job_i.value[9:0] & SURR_MASK};
          lo_done_d = job_i.done;
        end else begin
          out_d = '{unit: job_i.value[15:0], error_code: job_i.err,
                    last_of_run: 1'b1, string_done: job_i.done};
        end
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      lo_pend_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      lo_pend_q <= lo_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    lo_unit_q <= lo_unit_d;
    lo_done_q <= lo_done_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_transcoder_core.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
//
// Takes one UTF-8 byte per cycle and returns UTF-16 units in order: one unit
// per finished 1- to 3-byte sequence, a high/low surrogate pair for a 4-byte
// sequence, and one error result (unit 0) for a bad lead byte, a truncated
// sequence at the end mark, or a 4-byte value below 0x10000; after an error
// bytes are dropped up to the next end mark. A byte is decoded in the cycle
// it is accepted and its job queued; the back part then moves the job into the
// output register, which delivers one result per cycle when not stalled, so a
// surrogate pair holds it for its high and then its low unit. The input stalls
// only when the job queue (QueueDepth entries) is full, which happens under
// output backpressure or when other results follow closely on a surrogate pair.
`default_nettype none

module utf8_to_utf16_transcoder_core #(
  parameter int unsigned QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  u8u16_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output u8u16_pkg::out_t out_o
);
  import u8u16_pkg::*;

  qstat_t qstat;
  job_t   push_job, head_job;
  logic   push, pop;

  u8u16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (push_job)
  );

  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_checker.sv =====
// Port-level assertions for the transcoder, bound to its top level.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder_core.
`default_nettype none

module u8u16_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input u8u16_pkg::in_t  in_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input u8u16_pkg::out_t out_o
);
  import u8u16_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o & ~out_stall_i;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_i))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.error_code != ERR_NONE |->
      out_o.unit == 16'd0 && out_o.last_of_run)
    else $error("error result not zero or not last");

  a_hi_surr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last_of_run |->
      out_o.unit[15:10] == HI_SURR[15:10] && out_o.error_code == ERR_NONE)
    else $error("non-final result is not a high surrogate");

  a_lo_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_o.last_of_run |=>
      out_valid_o && out_o.last_of_run && out_o.unit[15:10] == LO_SURR[15:10]
      && out_o.string_done == $past(out_o.string_done))
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_u8u16_checker (.*);

`default_nettype wire

// ===== sim/u8u16_unit_checker.sv =====
// Checker for the UTF-8 to UTF-16 transcoder: predicts the UTF-16 units of each
// accepted byte request and compares them in order with the results.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_unit_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  u8u16_pkg::in_t    in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  u8u16_pkg::out_t   out_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       units_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  // Decoder state as the block should hold it.
  logic [1:0]  cont_left;
  logic [2:0]  seq_len;
  logic [20:0] code_acc;
  logic        dropping;

  out_t        expected_units[$];
  int unsigned mismatches;

  task automatic clear_sequence();
    cont_left = '0;
    seq_len   = 3'd1;
    code_acc  = '0;
  endtask

  task automatic push_unit(logic [15:0] u, err_e e, logic last, logic done);
    out_t r;
    r.unit        = u;
    r.error_code  = e;
    r.last_of_run = last;
    r.string_done = done;
    expected_units.insert(expected_units.size(), r);
  endtask

  // Error result; the rest of the string is dropped unless this byte ends it.
  task automatic flag_error(err_e e, logic eos);
    push_unit(16'h0000, e, 1'b1, eos);
    clear_sequence();
    dropping = !eos;
  endtask

  task automatic decode_utf8_byte(in_t req);
    logic [7:0]  b;
    logic        eos;
    int          ones;
    logic [20:0] v;
    b   = req.in_byte;
    eos = req.end_of_string;
    if (dropping) begin
      if (eos) begin
        dropping = 1'b0;
        clear_sequence();
      end
      return;
    end
    if (cont_left == 2'd0) begin
      ones = 0;
      while (ones < 8 && b[7-ones]) ones++;
      if (ones > 4) begin
        flag_error(ERR_BAD_LEAD, eos);
      end else if (ones <= 1) begin
        // ASCII, or a stray continuation byte passed through zero-extended
        push_unit({8'h00, b}, ERR_NONE, 1'b1, eos);
        clear_sequence();
      end else if (eos) begin
        flag_error(ERR_TRUNC, eos);
      end else begin
        seq_len   = 3'(ones);
        cont_left = 2'(ones - 1);
        case (ones)
          2:       code_acc = 21'(b & LEAD2_MASK);
          3:       code_acc = 21'(b & LEAD3_MASK);
          default: code_acc = 21'(b & LEAD4_MASK);
        endcase
      end
    end else begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) begin
        if (eos) flag_error(ERR_TRUNC, eos);
      end else if (seq_len == 3'd4) begin
        if (code_acc < SUPP_BASE) begin
          flag_error(ERR_LOW_4B, eos);
        end else begin
          v = code_acc - SUPP_BASE;
          push_unit(HI_SURR | {6'b0, v[19:10]}, ERR_NONE, 1'b0, eos);
          push_unit(LO_SURR | {6'b0, v[9:0]}, ERR_NONE, 1'b1, eos);
          clear_sequence();
        end
      end else begin
        push_unit(code_acc[15:0], ERR_NONE, 1'b1, eos);
        clear_sequence();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      clear_sequence();
      dropping = 1'b0;
      expected_units.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      units_pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_units.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: ", $realtime,
                     "unit=%h err=%0d last=%b done=%b", out_i.unit,
                     out_i.error_code, out_i.last_of_run, out_i.string_done);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (out_i.unit !== want.unit || out_i.error_code !== want.error_code ||
              out_i.last_of_run !== want.last_of_run ||
              out_i.string_done !== want.string_done) begin
            if (mismatches < 10)
              $display("%0t: mismatch: ", $realtime,
                       "expected unit=%h err=%0d last=%b done=%b, ", want.unit,
                       want.error_code, want.last_of_run, want.string_done,
                       "got unit=%h err=%0d last=%b done=%b", out_i.unit,
                       out_i.error_code, out_i.last_of_run, out_i.string_done);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_utf8_byte(in_i);
      mismatch_count_o <= mismatches;
      units_pending_o  <= unsigned'(expected_units.size());
    end
  end

endmodule

`default_nettype wire

// ===== sim/utf8_to_utf16_transcoder_core_tb.sv =====
// Testbench top for utf8_to_utf16_transcoder_core: drives byte strings and
// output backpressure, and gives the verdict from u8u16_unit_checker.
// Depends on u8u16_pkg, the transcoder RTL and sim/u8u16_unit_checker.sv.
`default_nettype none

module utf8_to_utf16_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned CycleLimit  = 200000;

  // {byte, end mark}
  localparam logic [8:0] DIRECTED_BYTES [28] = '{
    {8'h00, 1'b0}, {8'h7F, 1'b0}, {8'h80, 1'b0},                // ASCII ends, stray cont
    {8'hDF, 1'b0}, {8'hBF, 1'b0},                               // 2-byte max
    {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},                // 3-byte
    {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0}, // surrogate pair
    {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, // above range, unchecked
    {8'hF0, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1}, // low 4-byte at end
    {8'hF8, 1'b0}, {8'h41, 1'b0}, {8'hFF, 1'b1},                // bad lead, then dropped
    {8'hFF, 1'b1},                                              // bad lead at end
    {8'hC3, 1'b1},                                              // lead cut by end mark
    {8'hE2, 1'b0}, {8'h82, 1'b1},                               // cut mid sequence
    {8'h41, 1'b1}
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_req    = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_unit;
  int unsigned mismatch_count;
  int unsigned units_pending;

  logic        no_gaps     = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned stall_cycle = 0;
  int unsigned cycles      = 0;

  utf8_to_utf16_transcoder_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_unit)
  );

  u8u16_unit_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_i            (in_req),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_i           (out_unit),
    .mismatch_count_o(mismatch_count),
    .units_pending_o (units_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (rst_n) stall_cycle++;
    if (stall_cycle >= 300 && stall_cycle < 390) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 26);
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic eos);
    while (!no_gaps && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{in_byte: b, end_of_string: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Mostly well-formed characters with random payload; some noise bytes,
  // some low 4-byte values, and now and then a string cut short.
  task automatic offer_random_string();
    logic [7:0] bytes_q[$];
    int         chars;
    int         n;
    int         cut;
    logic [2:0] lead4;
    logic       low4;
    chars = $urandom_range(1, 6);
    repeat (chars) begin
      if ($urandom_range(0, 99) < 12) begin
        bytes_q.insert(bytes_q.size(), 8'($urandom_range(0, 255)));
      end else begin
        n    = $urandom_range(1, 4);
        low4 = 1'b0;
        case (n)
          1: bytes_q.insert(bytes_q.size(), {1'b0, 7'($urandom)});
          2: bytes_q.insert(bytes_q.size(), {3'b110, 5'($urandom)});
          3: bytes_q.insert(bytes_q.size(), {4'b1110, 4'($urandom)});
          default: begin
            lead4 = ($urandom_range(0, 3) == 0) ? 3'b000 : 3'($urandom);
            low4  = (lead4 == 3'b000) && $urandom_range(0, 1);
            bytes_q.insert(bytes_q.size(), {5'b11110, lead4});
          end
        endcase
        for (int k = 1; k < n; k++) begin
          if (low4 && k == 1) bytes_q.insert(bytes_q.size(), {4'b1000, 4'($urandom)});
          else bytes_q.insert(bytes_q.size(), {2'b10, 6'($urandom)});
        end
      end
    end
    if ($urandom_range(0, 99) < 10) begin
      cut = $urandom_range(1, bytes_q.size());
      while (bytes_q.size() > cut) void'(bytes_q.pop_back());
    end
    foreach (bytes_q[i]) offer_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  initial begin
    logic drained;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED_BYTES[i]) offer_byte(DIRECTED_BYTES[i][8:1], DIRECTED_BYTES[i][0]);
    while (items_sent < RandomItems) begin
      no_gaps = (items_sent >= 250 && items_sent < 330);
      if (!drained && items_sent >= 420) begin
        // sender pause until every expected unit is out
        in_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (units_pending != 0) @(posedge clk);
        drained = 1'b1;
      end
      offer_random_string();
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (units_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
